@@ rtl/multi_function_peripheral_irq_timers_defines.svh @@
// Assertion macros used by the peripheral's top level.
// Expects signals named clk and rst_n in the including scope.
`ifndef MULTI_FUNCTION_PERIPHERAL_IRQ_TIMERS_DEFINES_SVH
`define MULTI_FUNCTION_PERIPHERAL_IRQ_TIMERS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MFP_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MFP_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mfp_pkg.sv @@
// Package for the multi-function peripheral: codes, types and helper functions.
// Used by the divider, datapath, controller and top level; depends on nothing.
package mfp_pkg;

  // Request codes.
  localparam logic [2:0] REQ_READ    = 3'd0;
  localparam logic [2:0] REQ_WRITE   = 3'd1;
  localparam logic [2:0] REQ_ADVANCE = 3'd2;
  localparam logic [2:0] REQ_PINS    = 3'd3;
  localparam logic [2:0] REQ_EVENT   = 3'd4;
  localparam logic [2:0] REQ_ACK     = 3'd5;

  // Register addresses.
  localparam logic [4:0] ADR_GPDR  = 5'd0;
  localparam logic [4:0] ADR_AER   = 5'd1;
  localparam logic [4:0] ADR_DDR   = 5'd2;
  localparam logic [4:0] ADR_IERA  = 5'd3;
  localparam logic [4:0] ADR_IERB  = 5'd4;
  localparam logic [4:0] ADR_IPRA  = 5'd5;
  localparam logic [4:0] ADR_IPRB  = 5'd6;
  localparam logic [4:0] ADR_ISRA  = 5'd7;
  localparam logic [4:0] ADR_ISRB  = 5'd8;
  localparam logic [4:0] ADR_IMRA  = 5'd9;
  localparam logic [4:0] ADR_IMRB  = 5'd10;
  localparam logic [4:0] ADR_VR    = 5'd11;
  localparam logic [4:0] ADR_TACR  = 5'd12;
  localparam logic [4:0] ADR_TBCR  = 5'd13;
  localparam logic [4:0] ADR_TCDCR = 5'd14;
  localparam logic [4:0] ADR_TADR  = 5'd15;
  localparam logic [4:0] ADR_TBDR  = 5'd16;
  localparam logic [4:0] ADR_TCDR  = 5'd17;
  localparam logic [4:0] ADR_TDDR  = 5'd18;

  localparam int SOFT_EOI_BIT = 3;
  localparam int DIV_BITS     = 9;

  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_EVENT   = 2'd1,
    MODE_DELAY   = 2'd2,
    MODE_PULSE   = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_EXEC,
    CMD_PHASE_KEEP,
    CMD_PSC_START,
    CMD_PSC_DONE,
    CMD_CD_START,
    CMD_CD_FIN,
    CMD_TMR_NEXT
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TMR_CHECK,
    ST_PSC_WAIT,
    ST_CD_START,
    ST_CD_WAIT,
    ST_TMR_STEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic adv_go;
    logic evt_go;
    logic is_adv;
    logic tmr_active;
    logic div_ge;
    logic div_done;
    logic cd_need_div;
    logic tmr_last;
  } status_t;

  function automatic logic [7:0] prescale_lookup(input logic [2:0] sel);
    logic [7:0] p;
    unique case (sel)
      3'd0: p = 8'd1;
      3'd1: p = 8'd4;
      3'd2: p = 8'd10;
      3'd3: p = 8'd16;
      3'd4: p = 8'd50;
      3'd5: p = 8'd64;
      3'd6: p = 8'd100;
      default: p = 8'd200;
    endcase
    return p;
  endfunction

  // Request line: highest firing source, held off in software end-of-interrupt
  // mode by any in-service bit above it.
  function automatic logic line_eval(input logic [15:0] pending, input logic [15:0] mask,
                                     input logic [15:0] in_service, input logic soft_eoi);
    logic [15:0] firing;
    logic [15:0] fill;
    firing = pending & mask;
    fill = firing;
    fill = fill | (fill >> 1);
    fill = fill | (fill >> 2);
    fill = fill | (fill >> 4);
    fill = fill | (fill >> 8);
    if (firing == 16'h0) return 1'b0;
    if (!soft_eoi) return 1'b1;
    return ((in_service & ~fill) == 16'h0);
  endfunction

  function automatic logic [3:0] top_index(input logic [15:0] firing);
    logic [3:0] idx;
    idx = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (firing[i]) idx = 4'(i);
    end
    return idx;
  endfunction

  function automatic logic [15:0] port_bits(input logic [7:0] fall);
    return {fall[7:6], 6'b0, fall[5:4], 2'b0, fall[3:0]};
  endfunction

  function automatic logic [15:0] timer_irq_bit(input logic [1:0] t);
    logic [15:0] b;
    unique case (t)
      2'd0: b = 16'h2000;
      2'd1: b = 16'h0100;
      2'd2: b = 16'h0020;
      default: b = 16'h0010;
    endcase
    return b;
  endfunction

  function automatic mode_t ab_mode(input logic [7:0] v);
    mode_t m;
    if (v[3]) m = (v[2:0] != 3'd0) ? MODE_PULSE : MODE_EVENT;
    else      m = (v[2:0] != 3'd0) ? MODE_DELAY : MODE_STOPPED;
    return m;
  endfunction

  // Keeps the distance from the phase to the end of the prescale period.
  function automatic logic [9:0] phase_shift(input logic [9:0] phase, input logic [7:0] oldp,
                                             input logic [7:0] newp);
    return phase + {2'b0, newp} - {2'b0, oldp};
  endfunction

endpackage

@@ rtl/mfp_div.sv @@
// Shared restoring divider of the peripheral: one quotient bit per cycle.
// Depends on mfp_pkg for the number of quotient steps.
module mfp_div import mfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [8:0] dividend,
  input  logic [7:0] divisor,
  output logic       done,
  output logic [8:0] quotient,
  output logic [7:0] remainder
);

  logic       busy_r, busy_nxt;
  logic       done_r, done_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [8:0] quo_r, quo_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic [7:0] dvs_r, dvs_nxt;
  logic [8:0] trial;
  logic [8:0] diff;
  logic       ge;

  assign trial = {rem_r, quo_r[8]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 4'd0;
      quo_nxt  = dividend;
      rem_nxt  = 8'd0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[7:0], ge};
      rem_nxt = ge ? diff[7:0] : trial[7:0];
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'(DIV_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

@@ rtl/mfp_dp.sv @@
// Datapath of the peripheral: register file, interrupt logic, port edges, timers.
// Depends on mfp_pkg and instantiates the shared divider mfp_div.
module mfp_dp import mfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  output status_t    st,
  input  logic [2:0] in_req_type,
  input  logic [4:0] in_address,
  input  logic [7:0] in_write_data,
  input  logic [8:0] in_half_cycles,
  input  logic [7:0] in_port_pins,
  input  logic [1:0] in_event_channel,
  input  logic       in_event_level,
  output logic [7:0] res_read_data,
  output logic       res_irq_line,
  output logic       res_ack_valid,
  output logic [7:0] res_ack_vector
);

  // Captured item.
  logic [2:0] req_r, req_nxt;
  logic [4:0] addr_r, addr_nxt;
  logic [7:0] wdata_r, wdata_nxt;
  logic [8:0] half_r, half_nxt;
  logic [7:0] pins_r, pins_nxt;
  logic [1:0] ch_r, ch_nxt;
  logic       lvl_r, lvl_nxt;

  // Architectural state.
  logic [15:0] ien_r, ien_nxt, ipend_r, ipend_nxt, isvc_r, isvc_nxt, imask_r, imask_nxt;
  logic [7:0]  vector_r, vector_nxt;
  logic [7:0]  port_out_r, port_out_nxt, port_edge_r, port_edge_nxt;
  logic [7:0]  port_dir_r, port_dir_nxt, port_in_r, port_in_nxt, port_prev_r, port_prev_nxt;
  logic [7:0]  tab_ctrl_r [2];
  logic [7:0]  tab_ctrl_nxt [2];
  logic [7:0]  tcd_ctrl_r, tcd_ctrl_nxt;
  logic [7:0]  tcount_r [4];
  logic [7:0]  tcount_nxt [4];
  logic [7:0]  treload_r [4];
  logic [7:0]  treload_nxt [4];
  mode_t       tmode_r [4];
  mode_t       tmode_nxt [4];
  logic [7:0]  tpsc_r [4];
  logic [7:0]  tpsc_nxt [4];
  logic [9:0]  tphase_r [4];
  logic [9:0]  tphase_nxt [4];
  logic        evt_lvl_r [4];
  logic        evt_lvl_nxt [4];
  logic        half_rem_r, half_rem_nxt;
  logic        irq_out_r, irq_out_nxt;

  // Work registers of the timer sequence and the result.
  logic [8:0] cycles_r, cycles_nxt;
  logic [1:0] tmr_r, tmr_nxt;
  logic [8:0] amount_r, amount_nxt;
  logic [7:0] rd_r, rd_nxt;
  logic       ackv_r, ackv_nxt;
  logic [7:0] ackvec_r, ackvec_nxt;

  // Combinational helpers.
  logic        soft_eoi;
  logic [9:0]  total;
  logic        evt_changed, evt_active;
  logic [2:0]  evt_bit;
  logic [7:0]  pe_in, pe_dir, pe_edge, pe_level, pe_fall;
  logic [15:0] pe_pend;
  logic [15:0] firing, ack_h, ack_pend, ack_svc;
  logic [3:0]  ack_idx;
  logic [1:0]  ab_t, dr_t;
  logic [7:0]  ab_psc, c_psc, d_psc;
  logic [15:0] hi_word, keep;
  logic [10:0] div_s;
  logic        div_ge;
  logic [8:0]  cprime, a1;
  logic        cd_hit;
  logic [7:0]  reload_eff;
  logic [15:0] pend_raise;
  logic        div_start, div_done;
  logic [8:0]  div_dividend, div_quo;
  logic [7:0]  div_divisor, div_rem;

  assign soft_eoi    = vector_r[SOFT_EOI_BIT];
  assign total       = {1'b0, half_r} + {9'd0, half_rem_r};
  assign evt_bit     = 3'd4 - {1'b0, ch_r};
  assign evt_changed = evt_lvl_r[ch_r] != lvl_r;
  assign evt_active  = port_edge_r[evt_bit];

  assign pe_in    = (req_r == REQ_PINS) ? pins_r : port_in_r;
  assign pe_dir   = (req_r == REQ_WRITE && addr_r == ADR_DDR) ? wdata_r : port_dir_r;
  assign pe_edge  = (req_r == REQ_WRITE && addr_r == ADR_AER) ? wdata_r : port_edge_r;
  assign pe_level = (pe_in & ~pe_dir) ^ pe_edge;
  assign pe_fall  = port_prev_r & ~pe_level;
  assign pe_pend  = ipend_r | (port_bits(pe_fall) & ien_r);

  assign firing   = ipend_r & imask_r;
  assign ack_idx  = top_index(firing);
  assign ack_h    = 16'd1 << ack_idx;
  assign ack_pend = ipend_r & ~ack_h;
  assign ack_svc  = soft_eoi ? (isvc_r | ack_h) : isvc_r;

  assign ab_t    = {1'b0, addr_r[0]};
  assign dr_t    = 2'(addr_r - ADR_TADR);
  assign ab_psc  = prescale_lookup(wdata_r[2:0]);
  assign d_psc   = prescale_lookup(wdata_r[2:0]);
  assign c_psc   = prescale_lookup(wdata_r[6:4]);
  // Odd addresses hold the high byte of a 16-bit register.
  assign hi_word = addr_r[0] ? {wdata_r, 8'h00} : {8'h00, wdata_r};
  assign keep    = addr_r[0] ? 16'h00ff : 16'hff00;

  assign div_s      = {tphase_r[tmr_r][9], tphase_r[tmr_r]} + {2'b0, cycles_r};
  assign div_ge     = !div_s[10] && (div_s[9:0] >= {2'b0, tpsc_r[tmr_r]});
  // A count of zero is 256 steps away from its next zero crossing.
  assign cprime     = (tcount_r[tmr_r] == 8'd0) ? 9'd256 : {1'b0, tcount_r[tmr_r]};
  assign cd_hit     = cprime <= amount_r;
  assign a1         = amount_r - cprime;
  assign reload_eff = (tmode_r[tmr_r] == MODE_PULSE) ? 8'd0 : treload_r[tmr_r];
  assign pend_raise = ipend_r | (timer_irq_bit(tmr_r) & ien_r);

  assign div_start    = (cmd == CMD_PSC_START) ||
                        (cmd == CMD_CD_START && cd_hit && reload_eff != 8'd0);
  assign div_dividend = (cmd == CMD_PSC_START) ? div_s[8:0] : a1;
  assign div_divisor  = (cmd == CMD_PSC_START) ? tpsc_r[tmr_r] : reload_eff;

  mfp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    st.adv_go      = (req_r == REQ_ADVANCE) && (total[9:1] != 9'd0);
    st.evt_go      = (req_r == REQ_EVENT) && evt_changed &&
                     (tmode_r[ch_r] == MODE_EVENT) && (lvl_r == evt_active);
    st.is_adv      = req_r == REQ_ADVANCE;
    st.tmr_active  = tmode_r[tmr_r][1];
    st.div_ge      = div_ge;
    st.div_done    = div_done;
    st.cd_need_div = cd_hit && (reload_eff != 8'd0);
    st.tmr_last    = tmr_r == 2'd3;
  end

  always_comb begin
    req_nxt = req_r; addr_nxt = addr_r; wdata_nxt = wdata_r; half_nxt = half_r;
    pins_nxt = pins_r; ch_nxt = ch_r; lvl_nxt = lvl_r;
    ien_nxt = ien_r; ipend_nxt = ipend_r; isvc_nxt = isvc_r; imask_nxt = imask_r;
    vector_nxt = vector_r; port_out_nxt = port_out_r; port_edge_nxt = port_edge_r;
    port_dir_nxt = port_dir_r; port_in_nxt = port_in_r; port_prev_nxt = port_prev_r;
    tab_ctrl_nxt = tab_ctrl_r; tcd_ctrl_nxt = tcd_ctrl_r;
    tcount_nxt = tcount_r; treload_nxt = treload_r; tmode_nxt = tmode_r;
    tpsc_nxt = tpsc_r; tphase_nxt = tphase_r; evt_lvl_nxt = evt_lvl_r;
    half_rem_nxt = half_rem_r; irq_out_nxt = irq_out_r;
    cycles_nxt = cycles_r; tmr_nxt = tmr_r; amount_nxt = amount_r;
    rd_nxt = rd_r; ackv_nxt = ackv_r; ackvec_nxt = ackvec_r;

    unique case (cmd)
      CMD_LOAD: begin
        req_nxt = in_req_type; addr_nxt = in_address; wdata_nxt = in_write_data;
        half_nxt = in_half_cycles; pins_nxt = in_port_pins;
        ch_nxt = in_event_channel; lvl_nxt = in_event_level;
      end
      CMD_EXEC: begin
        rd_nxt = 8'd0;
        ackv_nxt = 1'b0;
        ackvec_nxt = 8'd0;
        unique case (req_r)
          REQ_READ: begin
            unique case (addr_r)
              ADR_GPDR:  rd_nxt = (port_in_r & ~port_dir_r) | (port_out_r & port_dir_r);
              ADR_AER:   rd_nxt = port_edge_r;
              ADR_DDR:   rd_nxt = port_dir_r;
              ADR_IERA:  rd_nxt = ien_r[15:8];
              ADR_IERB:  rd_nxt = ien_r[7:0];
              ADR_IPRA:  rd_nxt = ipend_r[15:8];
              ADR_IPRB:  rd_nxt = ipend_r[7:0];
              ADR_ISRA:  rd_nxt = isvc_r[15:8];
              ADR_ISRB:  rd_nxt = isvc_r[7:0];
              ADR_IMRA:  rd_nxt = imask_r[15:8];
              ADR_IMRB:  rd_nxt = imask_r[7:0];
              ADR_VR:    rd_nxt = vector_r;
              ADR_TACR:  rd_nxt = tab_ctrl_r[0];
              ADR_TBCR:  rd_nxt = tab_ctrl_r[1];
              ADR_TCDCR: rd_nxt = tcd_ctrl_r;
              ADR_TADR:  rd_nxt = tcount_r[0];
              ADR_TBDR:  rd_nxt = tcount_r[1];
              ADR_TCDR:  rd_nxt = tcount_r[2];
              ADR_TDDR:  rd_nxt = tcount_r[3];
              default:   rd_nxt = 8'd0;
            endcase
          end
          REQ_WRITE: begin
            unique case (addr_r)
              ADR_GPDR: port_out_nxt = wdata_r;
              ADR_AER, ADR_DDR: begin
                port_edge_nxt = pe_edge;
                port_dir_nxt  = pe_dir;
                port_prev_nxt = pe_level;
                if (pe_fall != 8'd0) begin
                  ipend_nxt   = pe_pend;
                  irq_out_nxt = line_eval(pe_pend, imask_r, isvc_r, soft_eoi);
                end
              end
              ADR_IERA, ADR_IERB: begin
                ien_nxt     = (ien_r & keep) | hi_word;
                ipend_nxt   = ipend_r & ien_nxt;
                irq_out_nxt = line_eval(ipend_nxt, imask_r, isvc_r, soft_eoi);
              end
              ADR_IPRA, ADR_IPRB: begin
                ipend_nxt   = ipend_r & (keep | hi_word);
                irq_out_nxt = line_eval(ipend_nxt, imask_r, isvc_r, soft_eoi);
              end
              ADR_ISRA, ADR_ISRB: begin
                isvc_nxt    = isvc_r & (keep | hi_word);
                irq_out_nxt = line_eval(ipend_r, imask_r, isvc_nxt, soft_eoi);
              end
              ADR_IMRA, ADR_IMRB: begin
                imask_nxt   = (imask_r & keep) | hi_word;
                irq_out_nxt = line_eval(ipend_r, imask_nxt, isvc_r, soft_eoi);
              end
              ADR_VR: begin
                vector_nxt = wdata_r;
                // Switching to automatic end-of-interrupt drops all in-service bits.
                if (!wdata_r[SOFT_EOI_BIT]) begin
                  isvc_nxt    = 16'h0;
                  irq_out_nxt = line_eval(ipend_r, imask_r, 16'h0, 1'b0);
                end
              end
              ADR_TACR, ADR_TBCR: begin
                tab_ctrl_nxt[addr_r[0]] = wdata_r;
                tmode_nxt[ab_t] = ab_mode(wdata_r);
                if (wdata_r[4]) begin
                  tphase_nxt[ab_t] = 10'd0;
                  tcount_nxt[ab_t] = treload_r[ab_t];
                end else begin
                  tphase_nxt[ab_t] = phase_shift(tphase_r[ab_t], tpsc_r[ab_t], ab_psc);
                end
                tpsc_nxt[ab_t] = ab_psc;
              end
              ADR_TCDCR: begin
                tcd_ctrl_nxt = wdata_r;
                tmode_nxt[3] = (wdata_r[2:0] != 3'd0) ? MODE_DELAY : MODE_STOPPED;
                tphase_nxt[3] = phase_shift(tphase_r[3], tpsc_r[3], d_psc);
                tpsc_nxt[3] = d_psc;
                tmode_nxt[2] = (wdata_r[6:4] != 3'd0) ? MODE_DELAY : MODE_STOPPED;
                tphase_nxt[2] = phase_shift(tphase_r[2], tpsc_r[2], c_psc);
                tpsc_nxt[2] = c_psc;
              end
              ADR_TADR, ADR_TBDR, ADR_TCDR, ADR_TDDR: begin
                if (tmode_r[dr_t] == MODE_STOPPED) tcount_nxt[dr_t] = wdata_r;
                treload_nxt[dr_t] = wdata_r;
              end
              default: ;
            endcase
          end
          REQ_ADVANCE: begin
            half_rem_nxt = total[0];
            cycles_nxt   = total[9:1];
            tmr_nxt      = 2'd0;
          end
          REQ_PINS: begin
            port_in_nxt   = pins_r;
            port_prev_nxt = pe_level;
            if (pe_fall != 8'd0) begin
              ipend_nxt   = pe_pend;
              irq_out_nxt = line_eval(pe_pend, imask_r, isvc_r, soft_eoi);
            end
          end
          REQ_EVENT: begin
            if (evt_changed) evt_lvl_nxt[ch_r] = lvl_r;
            tmr_nxt    = ch_r;
            amount_nxt = 9'd1;
          end
          REQ_ACK: begin
            if (firing != 16'h0) begin
              ipend_nxt   = ack_pend;
              isvc_nxt    = ack_svc;
              irq_out_nxt = line_eval(ack_pend, imask_r, ack_svc, soft_eoi);
              ackv_nxt    = 1'b1;
              ackvec_nxt  = {vector_r[7:4], ack_idx};
            end
          end
          default: ;
        endcase
      end
      CMD_PHASE_KEEP: tphase_nxt[tmr_r] = div_s[9:0];
      CMD_PSC_DONE: begin
        tphase_nxt[tmr_r] = {2'b0, div_rem};
        amount_nxt = div_quo;
      end
      CMD_CD_START: begin
        if (!cd_hit) begin
          tcount_nxt[tmr_r] = 8'(cprime - amount_r);
        end else begin
          ipend_nxt   = pend_raise;
          irq_out_nxt = line_eval(pend_raise, imask_r, isvc_r, soft_eoi);
          // Reload of zero: the count runs through all 256 values per period.
          if (reload_eff == 8'd0) tcount_nxt[tmr_r] = 8'd0 - a1[7:0];
        end
      end
      CMD_CD_FIN: begin
        tcount_nxt[tmr_r] = (div_rem == 8'd0) ? reload_eff : reload_eff - div_rem;
      end
      CMD_TMR_NEXT: tmr_nxt = tmr_r + 2'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ien_r <= 16'h0; ipend_r <= 16'h0; isvc_r <= 16'h0; imask_r <= 16'h0;
      vector_r <= 8'h0; port_out_r <= 8'h0; port_edge_r <= 8'h0;
      port_dir_r <= 8'h0; port_in_r <= 8'h0; port_prev_r <= 8'h0;
      tcd_ctrl_r <= 8'h0;
      half_rem_r <= 1'b0;
      irq_out_r <= 1'b0;
      for (int i = 0; i < 2; i++) tab_ctrl_r[i] <= 8'h0;
      for (int i = 0; i < 4; i++) begin
        tcount_r[i]  <= 8'h0;
        treload_r[i] <= 8'h0;
        tmode_r[i]   <= MODE_STOPPED;
        tpsc_r[i]    <= 8'd1;
        tphase_r[i]  <= 10'd0;
        evt_lvl_r[i] <= 1'b0;
      end
    end else begin
      ien_r <= ien_nxt; ipend_r <= ipend_nxt; isvc_r <= isvc_nxt; imask_r <= imask_nxt;
      vector_r <= vector_nxt; port_out_r <= port_out_nxt; port_edge_r <= port_edge_nxt;
      port_dir_r <= port_dir_nxt; port_in_r <= port_in_nxt; port_prev_r <= port_prev_nxt;
      tcd_ctrl_r <= tcd_ctrl_nxt;
      half_rem_r <= half_rem_nxt;
      irq_out_r <= irq_out_nxt;
      tab_ctrl_r <= tab_ctrl_nxt;
      tcount_r <= tcount_nxt;
      treload_r <= treload_nxt;
      tmode_r <= tmode_nxt;
      tpsc_r <= tpsc_nxt;
      tphase_r <= tphase_nxt;
      evt_lvl_r <= evt_lvl_nxt;
    end
    req_r <= req_nxt; addr_r <= addr_nxt; wdata_r <= wdata_nxt; half_r <= half_nxt;
    pins_r <= pins_nxt; ch_r <= ch_nxt; lvl_r <= lvl_nxt;
    cycles_r <= cycles_nxt; tmr_r <= tmr_nxt; amount_r <= amount_nxt;
    rd_r <= rd_nxt; ackv_r <= ackv_nxt; ackvec_r <= ackvec_nxt;
  end

  assign res_read_data  = rd_r;
  assign res_irq_line   = irq_out_r;
  assign res_ack_valid  = ackv_r;
  assign res_ack_vector = ackvec_r;

endmodule

@@ rtl/mfp_ctrl.sv @@
// Controller of the peripheral: sequences one item through the datapath.
// Depends on mfp_pkg for the state, command and status types.
module mfp_ctrl import mfp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  logic    out_free,
  output logic    load_out,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    in_stall  = 1'b1;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd = CMD_LOAD;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd = CMD_EXEC;
        if (st.adv_go)      state_nxt = ST_TMR_CHECK;
        else if (st.evt_go) state_nxt = ST_CD_START;
        else                state_nxt = ST_DONE;
      end
      ST_TMR_CHECK: begin
        if (!st.tmr_active) begin
          state_nxt = ST_TMR_STEP;
        end else if (!st.div_ge) begin
          cmd = CMD_PHASE_KEEP;
          state_nxt = ST_TMR_STEP;
        end else begin
          cmd = CMD_PSC_START;
          state_nxt = ST_PSC_WAIT;
        end
      end
      ST_PSC_WAIT: begin
        if (st.div_done) begin
          cmd = CMD_PSC_DONE;
          state_nxt = ST_CD_START;
        end
      end
      ST_CD_START: begin
        cmd = CMD_CD_START;
        if (st.cd_need_div) state_nxt = ST_CD_WAIT;
        else if (st.is_adv) state_nxt = ST_TMR_STEP;
        else                state_nxt = ST_DONE;
      end
      ST_CD_WAIT: begin
        if (st.div_done) begin
          cmd = CMD_CD_FIN;
          state_nxt = st.is_adv ? ST_TMR_STEP : ST_DONE;
        end
      end
      ST_TMR_STEP: begin
        if (st.tmr_last) begin
          state_nxt = ST_DONE;
        end else begin
          cmd = CMD_TMR_NEXT;
          state_nxt = ST_TMR_CHECK;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          load_out = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/multi_function_peripheral_irq_timers.sv @@
// Top level of the multi-function peripheral: controller, datapath, result register.
// Depends on mfp_pkg, mfp_ctrl, mfp_dp and the assertion macro header.
//
// The block takes one request per transfer on the input channel (in_valid,
// in_stall) and returns exactly one result per request on the output channel
// (out_valid, out_stall). A request is a bus read or write of the 32-address
// register file, a time advance, a port pin change, a timer event input change
// or an interrupt acknowledge. Configuration is done with bus writes.
// Reads, writes, pin changes, acknowledges and event changes that do not count
// pass through the execute state to the done state, where the result is loaded
// and out_valid rises; the next request is accepted in the cycle after the result
// is loaded, not before. An event that counts down a timer and a time advance
// use the shared nine-step divider; a counting event that wraps past zero
// needs at most one division and a time advance up to two per running timer,
// since each running timer may need one prescale division and one division
// by its reload value. The block works on one request at a time.
// The result register lets the block accept a new request while the previous
// result still waits; a finished request whose result cannot be loaded because
// the receiver stalls holds in its last state until the register is free.
// Synchronous reset clears the peripheral state and timers; prescalers reset to one.
`include "multi_function_peripheral_irq_timers_defines.svh"

module multi_function_peripheral_irq_timers import mfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_req_type,
  input  logic [4:0] in_address,
  input  logic [7:0] in_write_data,
  input  logic [8:0] in_half_cycles,
  input  logic [7:0] in_port_pins,
  input  logic [1:0] in_event_channel,
  input  logic       in_event_level,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data,
  output logic       out_irq_line,
  output logic       out_ack_valid,
  output logic [7:0] out_ack_vector
);

  status_t    st;
  cmd_t       cmd;
  logic       load_out;
  logic       out_free;
  logic [7:0] res_read_data, res_ack_vector;
  logic       res_irq_line, res_ack_valid;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_read_data_r, out_ack_vector_r;
  logic       out_irq_line_r, out_ack_valid_r;

  // The result register is free when empty or when its result leaves this cycle.
  assign out_free = !out_valid_r || !out_stall;

  mfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_free (out_free),
    .load_out (load_out),
    .st       (st),
    .cmd      (cmd)
  );

  mfp_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .in_req_type      (in_req_type),
    .in_address       (in_address),
    .in_write_data    (in_write_data),
    .in_half_cycles   (in_half_cycles),
    .in_port_pins     (in_port_pins),
    .in_event_channel (in_event_channel),
    .in_event_level   (in_event_level),
    .res_read_data    (res_read_data),
    .res_irq_line     (res_irq_line),
    .res_ack_valid    (res_ack_valid),
    .res_ack_vector   (res_ack_vector)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out)        out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
    if (load_out) begin
      out_read_data_r  <= res_read_data;
      out_irq_line_r   <= res_irq_line;
      out_ack_valid_r  <= res_ack_valid;
      out_ack_vector_r <= res_ack_vector;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = out_read_data_r;
  assign out_irq_line   = out_irq_line_r;
  assign out_ack_valid  = out_ack_valid_r;
  assign out_ack_vector = out_ack_vector_r;

  // A result is never loaded over one that the receiver has not yet taken.
  `MFP_ASSERT_IMP(a_no_overwrite, load_out, !out_valid_r || !out_stall,
    "result loaded over a stalled result")
  // A loaded result is presented in the next cycle.
  `MFP_ASSERT_NXT(a_load_shows, load_out, out_valid,
    "loaded result not presented")
  // After a transfer in, the block is busy until that request's result is loaded.
  `MFP_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
    "second request accepted while one is in progress")

endmodule
